@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file of this block.
// Both sample on the rising edge of clock; the first one is switched off while
// reset is high, the second one also looks at cycles in which reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define MFB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define MFB_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/core/mfb_pkg.sv @@
package mfb_pkg;

   localparam int MAX_WIDTH_DEFAULT = 128;

   localparam int PIXEL_W = 16;
   localparam int SUM_W   = 20;
   // One bit wider than the height register so the drain row past the last
   // row can still be counted.
   localparam int ROW_W   = 13;
   localparam int FW_W    = 8;
   localparam int FH_W    = 12;

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 8'd100;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 12'd100;

   // Division by 4, 6 or 9 is done as a multiply by a scaled reciprocal.
   // With a shift of 24 the result is exact for every dividend below 2^20.
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = 23;
   localparam logic [RECIP_W-1:0] RECIP_BY_4 = 23'd4194304;
   localparam logic [RECIP_W-1:0] RECIP_BY_6 = 23'd2796203;
   localparam logic [RECIP_W-1:0] RECIP_BY_9 = 23'd1864136;

   typedef enum logic [1:0] {
      DIV_BY_4,
      DIV_BY_6,
      DIV_BY_9
   } div_sel_type;

   // Which parts of the 3x3 window take part in the mean of one item.
   typedef struct packed {
      logic        produce;
      logic        last;
      logic        use_cur;
      logic        use_prv2;
      logic        top_ok;
      logic        bot_ok;
      div_sel_type div_sel;
   } win_ctl_type;

endpackage

@@ rtl/core/mfb_line_ram.sv @@
module mfb_line_ram #(
   parameter int DEPTH  = mfb_pkg::MAX_WIDTH_DEFAULT,
   parameter int DATA_W = mfb_pkg::PIXEL_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);
   import mfb_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // A read in the same cycle as a write to the same entry returns the new data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/mfb_window_sum.sv @@
module mfb_window_sum (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift_en,
   input  mfb_pkg::win_ctl_type        ctl,
   input  logic [mfb_pkg::PIXEL_W-1:0] top,
   input  logic [mfb_pkg::PIXEL_W-1:0] mid,
   input  logic [mfb_pkg::PIXEL_W-1:0] px,
   output logic [mfb_pkg::SUM_W-1:0]   sum
);
   import mfb_pkg::*;

   // Entries 0..2 hold the previous column (top row first), 3..5 the one before.
   logic [PIXEL_W-1:0] win_ff [6];

   logic [SUM_W-1:0] cur_sum;
   logic [SUM_W-1:0] prv_sum;
   logic [SUM_W-1:0] prv2_sum;
   logic [SUM_W-1:0] bias;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (shift_en) begin
         win_ff[3] <= win_ff[0];
         win_ff[4] <= win_ff[1];
         win_ff[5] <= win_ff[2];
         win_ff[0] <= top;
         win_ff[1] <= mid;
         win_ff[2] <= px;
      end
   end

   always_comb begin
      cur_sum  = SUM_W'(mid)
               + (ctl.top_ok ? SUM_W'(top) : '0)
               + (ctl.bot_ok ? SUM_W'(px) : '0);
      prv_sum  = SUM_W'(win_ff[1])
               + (ctl.top_ok ? SUM_W'(win_ff[0]) : '0)
               + (ctl.bot_ok ? SUM_W'(win_ff[2]) : '0);
      prv2_sum = SUM_W'(win_ff[4])
               + (ctl.top_ok ? SUM_W'(win_ff[3]) : '0)
               + (ctl.bot_ok ? SUM_W'(win_ff[5]) : '0);
      // Half the divisor, so the later truncating divide rounds to nearest.
      case (ctl.div_sel)
         DIV_BY_4: begin
            bias = SUM_W'(2);
         end
         DIV_BY_6: begin
            bias = SUM_W'(3);
         end
         DIV_BY_9: begin
            bias = SUM_W'(4);
         end
         default: begin
            bias = '0;
         end
      endcase
      sum = prv_sum + bias
          + (ctl.use_cur ? cur_sum : '0)
          + (ctl.use_prv2 ? prv2_sum : '0);
   end

endmodule

@@ rtl/core/mfb_round_div.sv @@
module mfb_round_div (
   input  logic [mfb_pkg::SUM_W-1:0]   sum,
   input  mfb_pkg::div_sel_type        div_sel,
   output logic [mfb_pkg::PIXEL_W-1:0] quotient
);
   import mfb_pkg::*;

   logic [RECIP_W-1:0]       recip;
   logic [SUM_W+RECIP_W-1:0] product;

   always_comb begin
      case (div_sel)
         DIV_BY_4: begin
            recip = RECIP_BY_4;
         end
         DIV_BY_6: begin
            recip = RECIP_BY_6;
         end
         DIV_BY_9: begin
            recip = RECIP_BY_9;
         end
         default: begin
            recip = RECIP_BY_4;
         end
      endcase
      product  = (SUM_W + RECIP_W)'(sum) * (SUM_W + RECIP_W)'(recip);
      // The sum already holds the rounding bias and never exceeds 9 * 65535 + 4,
      // so the quotient fits in a pixel.
      quotient = product[RECIP_SHIFT +: PIXEL_W];
   end

endmodule

@@ rtl/core/mean_filter_3x3_border_unit.sv @@
// 3x3 mean filter with border handling over a raster-ordered frame.
// Input channel (req_): one item per pixel in raster order. tdata carries the
// 16-bit unsigned pixel; tuser bit 0 is drain (tdata is ignored and a zero
// pixel is used) and bit 1 is frame_start (restarts at row 0, column 0).
// Result channel (rsp_): tdata is the rounded mean of the neighbors that lie
// inside the frame (9, 6 at an edge, 4 at a corner); tlast marks the result
// for the last pixel of the frame. A result belongs to the pixel one row plus
// one pixel before the item that completes its window, so after a frame the
// host sends frame_width + 1 drain items to flush the last row.
// Configuration (csr_): frame_width at index 0, frame_height at index 1, to be
// written by the host only while the block is idle; the block does not enforce it.
// Throughput is one item per cycle while the receiver keeps up. The accepting
// edge loads the input register and reads both line stores; the window sum is
// then registered in stage 2 and the reciprocal multiply in the output register,
// which drives rsp_tvalid. When the receiver stalls each stage holds its item
// and the input keeps accepting until all three stages are full. Reset clears
// the position counters, the window, all valid flags and sets both sizes to
// 100; the line stores are not cleared, since every entry is written before
// it is used.
module mean_filter_3x3_border_unit #(
   parameter int MAX_WIDTH = mfb_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mfb_pkg::PIXEL_W-1:0]      req_tdata,  // [15:0] pixel
   input  logic [1:0]                       req_tuser,  // [0] drain, [1] frame_start
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mfb_pkg::PIXEL_W-1:0]      rsp_tdata,  // [15:0] average
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [mfb_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [mfb_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mfb_pkg::*;

   // Column index width, and a compare width that holds both the width
   // register and MAX_WIDTH itself.
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = (AW + 1 > FW_W) ? AW + 1 : FW_W;

   // Configuration registers.
   logic [FW_W-1:0] frame_width_ff;
   logic [FH_W-1:0] frame_height_ff;

   // Position of the next item.
   logic [AW-1:0]    col_ff;
   logic [AW-1:0]    col_in;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;

   // Stage 1: accepted item, line store reads in flight.
   logic               s1_valid_ff;
   logic [PIXEL_W-1:0] s1_px_ff;
   logic [AW-1:0]      s1_col_ff;
   win_ctl_type        s1_ctl_ff;
   win_ctl_type        ctl_in;
   logic [PIXEL_W-1:0] px_in;

   // Stage 2: biased window sum.
   logic             s2_valid_ff;
   logic [SUM_W-1:0] s2_sum_ff;
   logic [SUM_W-1:0] s2_sum_in;
   div_sel_type      s2_sel_ff;
   logic             s2_last_ff;

   // Output register.
   logic               rsp_valid_ff;
   logic [PIXEL_W-1:0] rsp_avg_ff;
   logic [PIXEL_W-1:0] rsp_avg_in;
   logic               rsp_last_ff;

   // Handshake chain.
   logic out_ready;
   logic s2_ready;
   logic s1_ready;
   logic accept;
   logic s1_advance;

   // Position arithmetic.
   logic [WW-1:0]    eff_width;
   logic [WW-1:0]    fw_ext;
   logic [FH_W-1:0]  eff_height;
   logic [ROW_W-1:0] h_ext;
   logic [ROW_W-1:0] h_plus1;
   logic [ROW_W-1:0] h_plus2;
   logic [AW-1:0]    col_start;
   logic [ROW_W-1:0] row_start;
   logic             wrap_pre;
   logic [AW-1:0]    cur_col;
   logic [ROW_W-1:0] cur_row;
   logic [WW-1:0]    col_plus;
   logic             wrap_post;
   logic             rows3;
   logic             cols3;

   logic [PIXEL_W-1:0] top_rd;
   logic [PIXEL_W-1:0] mid_rd;

   //------------------------------------------------------------------------
   // Configuration.
   //------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_wdata[FW_W-1:0];
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wdata[FH_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   //------------------------------------------------------------------------
   // Handshake. Each stage takes a new item when it is empty or its item
   // moves on in the same cycle.
   //------------------------------------------------------------------------
   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || out_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;
   assign accept     = req_tvalid && s1_ready;
   assign s1_advance = s1_valid_ff && s2_ready;

   //------------------------------------------------------------------------
   // Position of the incoming item and which neighbors count for it.
   //------------------------------------------------------------------------
   always_comb begin
      // Width and height outside their range are clamped.
      fw_ext = WW'(frame_width_ff);
      if (fw_ext < WW'(3)) begin
         eff_width = WW'(3);
      end else if (fw_ext > WW'(MAX_WIDTH)) begin
         eff_width = WW'(MAX_WIDTH);
      end else begin
         eff_width = fw_ext;
      end
      eff_height = (frame_height_ff < FH_W'(3)) ? FH_W'(3) : frame_height_ff;
      h_ext   = ROW_W'(eff_height);
      h_plus1 = h_ext + ROW_W'(1);
      h_plus2 = h_ext + ROW_W'(2);

      col_start = req_tuser[1] ? '0 : col_ff;
      row_start = req_tuser[1] ? '0 : row_ff;

      // A column left beyond the width by a width change wraps first. The row
      // count stops two rows past the frame.
      wrap_pre = WW'(col_start) >= eff_width;
      cur_col  = wrap_pre ? '0 : col_start;
      cur_row  = (wrap_pre && (row_start < h_plus2)) ? row_start + ROW_W'(1) : row_start;

      col_plus  = WW'(cur_col) + WW'(1);
      wrap_post = col_plus >= eff_width;
      col_in    = wrap_post ? '0 : col_plus[AW-1:0];
      row_in    = (wrap_post && (cur_row < h_plus2)) ? cur_row + ROW_W'(1) : cur_row;

      px_in = req_tuser[0] ? '0 : req_tdata;

      if (cur_col == '0) begin
         // Column zero completes the last pixel of the row two rows back:
         // only the two window columns take part.
         ctl_in.produce  = (cur_row >= ROW_W'(2)) && (cur_row <= h_plus1);
         ctl_in.last     = (cur_row == h_plus1);
         ctl_in.use_cur  = 1'b0;
         ctl_in.use_prv2 = 1'b1;
         ctl_in.top_ok   = cur_row >= ROW_W'(3);
         ctl_in.bot_ok   = cur_row <= h_ext;
      end else begin
         ctl_in.produce  = (cur_row >= ROW_W'(1)) && (cur_row <= h_ext);
         ctl_in.last     = 1'b0;
         ctl_in.use_cur  = 1'b1;
         ctl_in.use_prv2 = WW'(cur_col) >= WW'(2);
         ctl_in.top_ok   = cur_row >= ROW_W'(2);
         ctl_in.bot_ok   = cur_row < h_ext;
      end

      cols3 = ctl_in.use_cur && ctl_in.use_prv2;
      rows3 = ctl_in.top_ok && ctl_in.bot_ok;
      if (cols3 && rows3) begin
         ctl_in.div_sel = DIV_BY_9;
      end else if (cols3 || rows3) begin
         ctl_in.div_sel = DIV_BY_6;
      end else begin
         ctl_in.div_sel = DIV_BY_4;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   //------------------------------------------------------------------------
   // Stage 1. The line stores are read when the item is accepted and written
   // when it moves on.
   //------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff  <= px_in;
         s1_col_ff <= cur_col;
         s1_ctl_ff <= ctl_in;
      end
   end

   mfb_line_ram #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (PIXEL_W)
   ) u_upper (
      .clock   (clock),
      .wr_en   (s1_advance),
      .wr_addr (s1_col_ff),
      .wr_data (mid_rd),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (top_rd)
   );

   mfb_line_ram #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (PIXEL_W)
   ) u_middle (
      .clock   (clock),
      .wr_en   (s1_advance),
      .wr_addr (s1_col_ff),
      .wr_data (s1_px_ff),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (mid_rd)
   );

   mfb_window_sum u_window (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_advance),
      .ctl      (s1_ctl_ff),
      .top      (top_rd),
      .mid      (mid_rd),
      .px       (s1_px_ff),
      .sum      (s2_sum_in)
   );

   //------------------------------------------------------------------------
   // Stage 2. Items that complete no neighborhood are dropped here.
   //------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff && s1_ctl_ff.produce;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         s2_sum_ff  <= s2_sum_in;
         s2_sel_ff  <= s1_ctl_ff.div_sel;
         s2_last_ff <= s1_ctl_ff.last;
      end
   end

   mfb_round_div u_div (
      .sum      (s2_sum_ff),
      .div_sel  (s2_sel_ff),
      .quotient (rsp_avg_in)
   );

   //------------------------------------------------------------------------
   // Output register.
   //------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && out_ready) begin
         rsp_avg_ff  <= rsp_avg_in;
         rsp_last_ff <= s2_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_avg_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ rtl/core/mfb_checker.sv @@
`include "assert_macros.svh"

module mfb_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [mfb_pkg::PIXEL_W-1:0] rsp_tdata,
   input logic                        rsp_tlast
);
   import mfb_pkg::*;

   // After reset, no result can come out before an item has passed all three stages.
   `MFB_ASSERT_RST(a_quiet_after_reset, reset |=> !rsp_tvalid ##1 !rsp_tvalid ##1 !rsp_tvalid, "result too soon after reset")

   // With the output free, the whole pipeline can move, so the input is open.
   `MFB_ASSERT(a_ready_when_flowing, (rsp_tready || !rsp_tvalid) |-> req_tready, "input blocked while output is free")

   // An item that was not taken stays with the same value and frame mark.
   `MFB_ASSERT(a_hold_on_stall, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled result changed")

   // The input only closes when a result is waiting at the output.
   `MFB_ASSERT(a_block_needs_result, !req_tready |-> rsp_tvalid && !rsp_tready, "input blocked without a stalled result")

endmodule

bind mean_filter_3x3_border_unit mfb_checker u_mfb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

@@ sim/tb.sv @@
module tb;
   import mfb_pkg::*;

   // Sizes and timing of the bench. A result passes the input register, stage 2
   // and the output register before rsp_tvalid rises, so SETTLE leaves ample room
   // for the pipeline to empty after items that cause no result.
   localparam int MAX_W        = MAX_WIDTH_DEFAULT;
   localparam int COL_W        = $clog2(MAX_W);
   localparam int RESET_CYCLES = 5;
   localparam int SETTLE       = 10;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 1565;
   localparam int MAX_REPORTS  = 50;

   // One input item as the bench keeps it. When known is set, the result of
   // this item is written into the table by hand and replaces the prediction.
   typedef struct packed {
      logic [15:0] pixel;
      logic        drain;
      logic        start;
      logic        known;
      logic [15:0] known_mean;
      logic        known_end;
   } pixel_item_type;

   typedef struct packed {
      logic [15:0] mean;
      logic        frame_end;
   } mean_result_type;

   // Ways the result side takes items when it is not held off.
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_ALTERNATE
   } ready_style_type;

   // Opening table, run with a 3x3 frame. The first frame is all full-scale
   // pixels, so every mean is full scale and only the flush result for the
   // bottom-right corner carries the frame end. The second frame starts with
   // a drain item that also starts the frame (it counts as a zero pixel), has
   // a drain in the middle whose pixel must be ignored, and ends with a pixel
   // sent after the flush, which lies past the last row and yields nothing.
   localparam pixel_item_type DIRECTED [27] = '{
      '{16'hFFFF, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{16'hFFFF, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'hFFFF, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'hFFFF, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'hFFFF, 1'b0, 1'b0, 1'b1, 16'hFFFF, 1'b0},
      '{16'hFFFF, 1'b0, 1'b0, 1'b1, 16'hFFFF, 1'b0},
      '{16'hFFFF, 1'b0, 1'b0, 1'b1, 16'hFFFF, 1'b0},
      '{16'hFFFF, 1'b0, 1'b0, 1'b1, 16'hFFFF, 1'b0},
      '{16'hFFFF, 1'b0, 1'b0, 1'b1, 16'hFFFF, 1'b0},
      '{16'h0000, 1'b1, 1'b0, 1'b1, 16'hFFFF, 1'b0},
      '{16'h0000, 1'b1, 1'b0, 1'b1, 16'hFFFF, 1'b0},
      '{16'h0000, 1'b1, 1'b0, 1'b1, 16'hFFFF, 1'b0},
      '{16'h0000, 1'b1, 1'b0, 1'b1, 16'hFFFF, 1'b1},
      '{16'hFFFF, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0},
      '{16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'h8000, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'h0001, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'hABCD, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'hFFFF, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'h7FFF, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'h5555, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'hAAAA, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'h1234, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'hFFFF, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'h0000, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'hC3C3, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0},
      '{16'hFFFF, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0}
   };

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIXEL_W-1:0]    req_tdata  = '0;  // [15:0] pixel
   logic [1:0]            req_tuser  = '0;  // [0] drain, [1] frame_start
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [PIXEL_W-1:0]    rsp_tdata;        // [15:0] average
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   mean_filter_3x3_border_unit #(
      .MAX_WIDTH (MAX_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Filter state as the bench tracks it. The line stores are cleared here
   // only for tidiness: the stimulus never lets an unwritten entry reach a
   // result, so their start value does not matter.
   // ------------------------------------------------------------------
   logic [15:0] upper_row  [MAX_W] = '{default: '0};
   logic [15:0] middle_row [MAX_W] = '{default: '0};
   logic [15:0] window_px  [6]     = '{default: '0};
   logic [7:0]  col_pos    = '0;
   logic [12:0] row_pos    = '0;
   logic [7:0]  width_reg  = FRAME_WIDTH_RESET;
   logic [11:0] height_reg = FRAME_HEIGHT_RESET;

   pixel_item_type  stim_q [$];
   mean_result_type pending_means [$];
   int              items_pending = 0;
   int              mismatches    = 0;

   // Widths below 3 act as 3 and widths past the line store act as its depth;
   // heights below 3 act as 3.
   function automatic logic [7:0] active_width();
      if (width_reg < 8'd3) begin
         return 8'd3;
      end
      if (width_reg > 8'(MAX_W)) begin
         return 8'(MAX_W);
      end
      return width_reg;
   endfunction

   function automatic logic [12:0] active_height();
      return (height_reg < 12'd3) ? 13'd3 : {1'b0, height_reg};
   endfunction

   // Moves the filter state on by one accepted item and works out the mean
   // that the item completes, if any. An item at column c > 0 completes the
   // pixel one row up and one column left; an item at column 0 completes the
   // last column of the row two up, using only the two window columns.
   function automatic void box_mean_step(input pixel_item_type item, output logic hit,
                                         output mean_result_type res);
      logic [7:0]  w;
      logic [12:0] h;
      logic [15:0] px;
      logic [15:0] top;
      logic [15:0] mid;
      logic [7:0]  c;
      logic [12:0] r;
      logic [19:0] sum;
      logic [3:0]  cnt;
      logic        last;
      int          i;
      w    = active_width();
      h    = active_height();
      px   = item.drain ? 16'h0000 : item.pixel;
      sum  = '0;
      cnt  = '0;
      hit  = 1'b0;
      last = 1'b0;
      res  = '0;
      if (item.start) begin
         col_pos = '0;
         row_pos = '0;
      end
      // A column left past the width by a width change wraps to a new row.
      if (col_pos >= w) begin
         col_pos = '0;
         if (row_pos < h + 13'd2) begin
            row_pos = row_pos + 13'd1;
         end
      end
      c   = col_pos;
      r   = row_pos;
      top = upper_row[c[COL_W-1:0]];
      mid = middle_row[c[COL_W-1:0]];
      if (c >= 8'd1) begin
         if (r >= 13'd1 && r <= h) begin
            sum = sum + mid + window_px[1];
            cnt = 4'd2;
            if (c >= 8'd2) begin
               sum = sum + window_px[4];
               cnt = cnt + 4'd1;
            end
            if (r >= 13'd2) begin
               sum = sum + top + window_px[0];
               cnt = cnt + 4'd2;
               if (c >= 8'd2) begin
                  sum = sum + window_px[3];
                  cnt = cnt + 4'd1;
               end
            end
            if (r < h) begin
               sum = sum + px + window_px[2];
               cnt = cnt + 4'd2;
               if (c >= 8'd2) begin
                  sum = sum + window_px[5];
                  cnt = cnt + 4'd1;
               end
            end
            hit = 1'b1;
         end
      end else if (r >= 13'd2 && r <= h + 13'd1) begin
         for (i = 0; i < 6; i += 3) begin
            sum = sum + window_px[i + 1];
            cnt = cnt + 4'd1;
            if (r >= 13'd3) begin
               sum = sum + window_px[i];
               cnt = cnt + 4'd1;
            end
            if (r <= h) begin
               sum = sum + window_px[i + 2];
               cnt = cnt + 4'd1;
            end
         end
         last = (r == h + 13'd1);
         hit  = 1'b1;
      end
      if (hit) begin
         // Round to nearest, ties up.
         res.mean      = 16'((sum + 20'(cnt >> 1)) / 20'(cnt));
         res.frame_end = last;
      end
      window_px[3]  = window_px[0];
      window_px[4]  = window_px[1];
      window_px[5]  = window_px[2];
      window_px[0]  = top;
      window_px[1]  = mid;
      window_px[2]  = px;
      upper_row[c[COL_W-1:0]]  = mid;
      middle_row[c[COL_W-1:0]] = px;
      col_pos = c + 8'd1;
      if (col_pos >= w) begin
         col_pos = '0;
         if (row_pos < h + 13'd2) begin
            row_pos = row_pos + 13'd1;
         end
      end
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("mismatch at %0t: %s", $time, what);
      end
   endtask

   // ------------------------------------------------------------------
   // Input side. The sender offers items in bursts of random length with
   // random gaps; now and then a long burst runs without any gap. An offered
   // item is held until the block takes it.
   // ------------------------------------------------------------------
   pixel_item_type offered_item = '0;
   int             burst_left   = 0;
   int             gap_left     = 0;

   always @(posedge clock) begin : sender
      pixel_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (stim_q.size() != 0) begin
            item = stim_q.pop_front();
            offered_item <= item;
            req_tdata    <= item.pixel;
            req_tuser    <= {item.start, item.drain};
            req_tvalid   <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                        : $urandom_range(1, 16);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Every accepted item goes through the predictor at the edge that takes
   // it. Rows of the opening table with a hand-written result use that result
   // instead of the predicted one.
   always @(posedge clock) begin : accept_monitor
      logic            hit;
      mean_result_type res;
      if (!reset && req_tvalid && req_tready) begin
         box_mean_step(offered_item, hit, res);
         if (hit) begin
            if (offered_item.known) begin
               res.mean      = offered_item.known_mean;
               res.frame_end = offered_item.known_end;
            end
            pending_means.push_back(res);
         end
         items_pending--;
      end
   end

   // ------------------------------------------------------------------
   // Result side. Readiness follows a style that is picked afresh at random
   // intervals. Once, on request, it is held low for a long stretch while the
   // sender keeps offering, so the pipeline fills and the input stalls.
   // ------------------------------------------------------------------
   logic            hold_req     = 1'b0;
   bit              hold_taken   = 1'b0;
   int              hold_left    = 0;
   int              pattern_left = 0;
   ready_style_type ready_style  = READY_ALWAYS;

   always @(posedge clock) begin : receiver
      if (hold_req && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(20, 80);
            ready_style  = ready_style_type'($urandom_range(0, 3));
         end
         pattern_left--;
         case (ready_style)
            READY_ALWAYS:    rsp_tready <= 1'b1;
            READY_COIN:      rsp_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE:    rsp_tready <= ($urandom_range(0, 3) == 0);
            READY_ALTERNATE: rsp_tready <= !rsp_tready;
            default:         rsp_tready <= 1'b1;
         endcase
      end
   end

   // Each result is matched against the oldest expected mean.
   always @(posedge clock) begin : result_monitor
      mean_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_means.size() == 0) begin
            note_mismatch($sformatf("result %h (end %b) with none expected",
                                    rsp_tdata, rsp_tlast));
         end else begin
            want = pending_means.pop_front();
            if (rsp_tdata !== want.mean) begin
               note_mismatch($sformatf("average %h, expected %h", rsp_tdata, want.mean));
            end
            if (rsp_tlast !== want.frame_end) begin
               note_mismatch($sformatf("frame end %b, expected %b on average %h",
                                       rsp_tlast, want.frame_end, want.mean));
            end
         end
      end
   end

   // The run is stuck if neither side moves an item for this long. The
   // longest legal quiet stretch is the forced hold-off of the result side.
   int quiet_cycles = 0;

   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("mean_filter_3x3_border_unit regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------
   function automatic logic [15:0] random_pixel();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   task automatic push_item(input logic [15:0] pixel, input logic drain, input logic start);
      pixel_item_type item;
      item       = '0;
      item.pixel = pixel;
      item.drain = drain;
      item.start = start;
      stim_q.push_back(item);
      items_pending++;
   endtask

   // A register is written only when the block is idle, so the bench copy
   // can follow it at once.
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      if (addr == CSR_FRAME_WIDTH) begin
         width_reg = data[FW_W-1:0];
      end else begin
         height_reg = data[FH_W-1:0];
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Waits until every item has been taken and every expected mean has come
   // back, then lets the pipeline run empty of items that cause no result.
   task automatic wait_idle();
      while (items_pending != 0 || pending_means.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   // One frame at the current size, then the width + 1 drain items that
   // push out its last row. A frame cut short gets no flush; the next frame
   // start then drops whatever it left pending. Returns the items queued.
   task automatic send_frame(input bit cut_short, output int queued);
      int w;
      int h;
      int total;
      int stop;
      int k;
      w      = int'(active_width());
      h      = int'(active_height());
      total  = w * h;
      stop   = cut_short ? $urandom_range(1, total - 1) : total;
      queued = stop;
      for (k = 0; k < stop; k++) begin
         push_item(random_pixel(), ($urandom_range(0, 19) == 0), (k == 0));
      end
      if (!cut_short) begin
         for (k = 0; k <= w; k++) begin
            push_item(random_pixel(), 1'b1, 1'b0);
         end
         queued += w + 1;
      end
   endtask

   // Picks the next frame size. Most frames are small; a few go to the
   // largest width or to the values below the legal range.
   task automatic pick_sizes(input bit widest);
      logic [7:0]  w;
      logic [11:0] h;
      case ($urandom_range(0, 11))
         0: begin
            w = 8'($urandom_range(128, 255));
            h = 12'($urandom_range(0, 3));
         end
         1: begin
            w = 8'($urandom_range(0, 2));
            h = 12'($urandom_range(0, 6));
         end
         2: begin
            w = 8'($urandom_range(3, 12));
            h = 12'($urandom_range(0, 2));
         end
         default: begin
            w = 8'($urandom_range(3, 16));
            h = 12'($urandom_range(3, 10));
         end
      endcase
      if (widest) begin
         w = 8'(MAX_W);
         h = 12'd3;
      end
      // The spare upper bits of the write data are junk on width writes.
      write_csr(CSR_FRAME_WIDTH, {4'($urandom_range(0, 15)), w});
      write_csr(CSR_FRAME_HEIGHT, h);
   endtask

   // ------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------
   initial begin : sequencer
      int k;
      int queued;
      int random_sent;
      int frame_no;
      bit cut;
      bit flushed;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Opening table on the smallest frame.
      write_csr(CSR_FRAME_WIDTH, 12'd3);
      write_csr(CSR_FRAME_HEIGHT, 12'd3);
      for (k = 0; k < $size(DIRECTED); k++) begin
         stim_q.push_back(DIRECTED[k]);
         items_pending++;
      end
      wait_idle();

      // Narrow the width in the middle of a frame: the column count is then
      // past the new width and the next item wraps to a new row. Only a
      // narrowing is safe, since every column it reads was written above.
      write_csr(CSR_FRAME_WIDTH, 12'd8);
      write_csr(CSR_FRAME_HEIGHT, 12'd6);
      for (k = 0; k < 3 * 8 + 5; k++) begin
         push_item(random_pixel(), 1'b0, (k == 0));
      end
      wait_idle();
      write_csr(CSR_FRAME_WIDTH, 12'd4);
      for (k = 0; k < 3 * 4 + 5; k++) begin
         push_item(random_pixel(), (k >= 12), 1'b0);
      end
      wait_idle();

      // The tallest height with the narrowest width, cut short after a few
      // rows; the next frame start drops what it left pending.
      write_csr(CSR_FRAME_WIDTH, 12'hF03);
      write_csr(CSR_FRAME_HEIGHT, 12'hFFF);
      for (k = 0; k < 4 * 3; k++) begin
         push_item(random_pixel(), 1'b0, (k == 0));
      end
      wait_idle();

      // Random frames. The first one uses the full line width, the second
      // runs into the long hold-off on the result side.
      random_sent = 0;
      frame_no    = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (frame_no == 0 || $urandom_range(0, 2) == 0) begin
            wait_idle();
            pick_sizes(frame_no == 0);
         end
         if (frame_no == 1) begin
            hold_req <= 1'b1;
         end
         cut = ($urandom_range(0, 9) == 0);
         send_frame(cut, queued);
         random_sent += queued;
         flushed = !cut;
         // Items past the flushed frame land beyond the last row and are
         // ignored, with or without the drain flag.
         if (flushed && $urandom_range(0, 3) == 0) begin
            for (k = $urandom_range(1, 3); k > 0; k--) begin
               push_item(random_pixel(), 1'($urandom_range(0, 1)), 1'b0);
            end
         end
         frame_no++;
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("mean_filter_3x3_border_unit regression: pass");
      end else begin
         $display("mean_filter_3x3_border_unit regression: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/mfb_pkg.sv
rtl/core/mfb_line_ram.sv
rtl/core/mfb_window_sum.sv
rtl/core/mfb_round_div.sv
rtl/core/mean_filter_3x3_border_unit.sv
rtl/core/mfb_checker.sv
sim/tb.sv
